FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/stpf_pkg.sv
// Package for the sorted table with prime filter: request codes, status codes,
// state machine encoding and sizing constants. No dependencies.
package stpf_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned ValW  = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned CntW  = 7;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned StatW = 2;

  localparam logic [ReqW-1:0] ReqInsert = 3'd0;
  localparam logic [ReqW-1:0] ReqRemove = 3'd1;
  localparam logic [ReqW-1:0] ReqAsc    = 3'd2;
  localparam logic [ReqW-1:0] ReqCross  = 3'd3;
  localparam logic [ReqW-1:0] ReqPrime  = 3'd4;

  localparam logic [StatW-1:0] StOk       = 2'd0;
  localparam logic [StatW-1:0] StNotFound = 2'd1;
  localparam logic [StatW-1:0] StFull     = 2'd2;
  localparam logic [StatW-1:0] StRange    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRIME,      // trial division, one bit of quotient per cycle
    S_INS_RD,     // read sorted[slot-1]
    S_INS_CMP,    // compare and shift
    S_REM_SCAN,   // compact insertion store
    S_REM_SORT,   // compact sorted store
    S_RD_WAIT,    // single memory read
    S_PR_SCAN,    // k-th prime scan
    S_OUT
  } state_e;

endpackage

FILE: hw/rtl/sorted_table_with_prime_filter.sv
// Top level of the sorted table with prime filter: request FSM, two
// memories (insertion order with prime flag, sorted) and a serial divider.
// Depends on stpf_pkg and assert_macros.svh.
//
//  channel | signals                                              | dir
//  req     | req_valid_i/ready_o, req_type_i, value_i, position_i | in
//  rsp     | rsp_valid_o/ready_i, data_o, status_o, counts        | out
//
// Ascending and side-cross reads pass S_RD_WAIT and S_OUT before the result
// is valid, out of range ones only S_OUT. Prime read scans the insertion
// store to the requested prime or its end. Insert: per divisor from 2 up, a
// 32-step restoring division and a decision step, until a divisor divides
// the value or its square exceeds it; then a read and compare per sorted
// entry, shifting larger ones up. Remove: two passes, the second if the
// value was found. One transaction at a time; the result register holds until
// taken. Reset clears counts and control only; stores need no clearing.
`include "assert_macros.svh"

module sorted_table_with_prime_filter #(
  parameter int unsigned CAPACITY = stpf_pkg::CapacityDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [stpf_pkg::ReqW-1:0]   req_type_i,
  input  logic signed [31:0]          value_i,
  input  logic [stpf_pkg::PosW-1:0]   position_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output logic signed [31:0]          data_o,
  output logic [stpf_pkg::StatW-1:0]  status_o,
  output logic [stpf_pkg::CntW-1:0]   entry_count_o,
  output logic [stpf_pkg::CntW-1:0]   prime_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // wide enough for the count and for any position compare
  localparam int unsigned NW = ($clog2(CAPACITY + 1) > stpf_pkg::CntW) ?
                               $clog2(CAPACITY + 1) : stpf_pkg::CntW;

  stpf_pkg::state_e state_q, state_d;

  // memories: insertion order holds {prime flag, value}
  logic [32:0]        ins_mem [CAPACITY];
  logic signed [31:0] srt_mem [CAPACITY];

  logic          ins_we, srt_we;
  logic [AW-1:0] ins_wa, srt_wa, ins_ra, srt_ra;
  logic [32:0]   ins_wd, ins_rd_q;
  logic signed [31:0] srt_wd, srt_rd_q;
  logic signed [31:0] ins_val;
  logic          ins_flg;

  always_ff @(posedge clk_i) begin
    if (ins_we) ins_mem[ins_wa] <= ins_wd;
    if (srt_we) srt_mem[srt_wa] <= srt_wd;
    ins_rd_q <= ins_mem[ins_ra];
    srt_rd_q <= srt_mem[srt_ra];
  end

  assign ins_val = ins_rd_q[31:0];
  assign ins_flg = ins_rd_q[32];

  // control and payload registers
  logic [NW-1:0] cnt_q, cnt_d, pcnt_q, pcnt_d;
  logic signed [31:0] val_q, val_d;
  logic [stpf_pkg::PosW-1:0] pos_q, pos_d;
  logic [NW-1:0] i_q, i_d, w_q, w_d, k_q, k_d;
  logic found_q, found_d, isp_q, isp_d;
  logic signed [31:0] dat_q, dat_d;
  logic [stpf_pkg::StatW-1:0] st_q, st_d;
  logic rv_q, rv_d;

  // serial divider: remainder of val by div, 32 steps
  logic [31:0] div_q, div_d, rem_q, rem_d, dvd_q, dvd_d;
  logic [5:0]  dstep_q, dstep_d;
  logic [32:0] rem_sh;
  logic [63:0] dsq;
  assign rem_sh = {rem_q, dvd_q[31]};
  assign dsq    = 64'(div_q) * 64'(div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stpf_pkg::S_IDLE;
      cnt_q   <= '0;
      pcnt_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pcnt_q  <= pcnt_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d; pos_q <= pos_d;
    i_q <= i_d; w_q <= w_d; k_q <= k_d;
    found_q <= found_d; isp_q <= isp_d;
    dat_q <= dat_d; st_q <= st_d;
    div_q <= div_d; rem_q <= rem_d; dvd_q <= dvd_d; dstep_q <= dstep_d;
  end

  logic accept;
  assign req_ready_o = (state_q == stpf_pkg::S_IDLE) && !rv_q;
  assign accept      = req_valid_i && req_ready_o;

  logic [NW:0] cross_idx;
  assign cross_idx = (NW+1)'(cnt_q) - (NW+1)'(1) - (NW+1)'(position_i >> 1);

  // entry i-1 of the insertion store matches the value being removed
  logic rem_hit;
  assign rem_hit = (i_q != '0) && (ins_val == val_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stpf_pkg::S_IDLE: begin
        if (accept) begin
          case (req_type_i)
            stpf_pkg::ReqInsert:
              state_d = (cnt_q >= NW'(CAPACITY)) ? stpf_pkg::S_OUT
                      : (value_i > 32'sd3) ? stpf_pkg::S_PRIME : stpf_pkg::S_INS_RD;
            stpf_pkg::ReqRemove: state_d = stpf_pkg::S_REM_SCAN;
            stpf_pkg::ReqAsc, stpf_pkg::ReqCross:
              state_d = (NW'(position_i) < cnt_q) ? stpf_pkg::S_RD_WAIT
                                                  : stpf_pkg::S_OUT;
            stpf_pkg::ReqPrime: state_d = stpf_pkg::S_PR_SCAN;
            default: state_d = stpf_pkg::S_OUT;
          endcase
        end
      end
      stpf_pkg::S_PRIME: begin
        if (dstep_q == 6'd32) begin
          if (rem_q == 32'd0 || dsq > 64'(val_q)) state_d = stpf_pkg::S_INS_RD;
        end
      end
      stpf_pkg::S_INS_RD:  state_d = (i_q == '0) ? stpf_pkg::S_OUT : stpf_pkg::S_INS_CMP;
      stpf_pkg::S_INS_CMP: state_d = (srt_rd_q > val_q) ? stpf_pkg::S_INS_RD
                                                         : stpf_pkg::S_OUT;
      stpf_pkg::S_REM_SCAN:
        if (i_q == cnt_q) state_d = (found_q || rem_hit) ? stpf_pkg::S_REM_SORT
                                                         : stpf_pkg::S_OUT;
      stpf_pkg::S_REM_SORT: if (i_q == cnt_q) state_d = stpf_pkg::S_OUT;
      stpf_pkg::S_RD_WAIT: state_d = stpf_pkg::S_OUT;
      stpf_pkg::S_PR_SCAN:
        if (i_q != '0 && ins_flg && k_q == NW'(pos_q)) state_d = stpf_pkg::S_OUT;
        else if (i_q == cnt_q) state_d = stpf_pkg::S_OUT;
      stpf_pkg::S_OUT: state_d = stpf_pkg::S_IDLE;
      default: state_d = stpf_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_d = cnt_q; pcnt_d = pcnt_q; val_d = val_q; pos_d = pos_q;
    i_d = i_q; w_d = w_q; k_d = k_q; found_d = found_q; isp_d = isp_q;
    dat_d = dat_q; st_d = st_q; rv_d = rv_q;
    div_d = div_q; rem_d = rem_q; dvd_d = dvd_q; dstep_d = dstep_q;
    ins_we = 1'b0; srt_we = 1'b0;
    ins_wa = '0; srt_wa = '0; ins_ra = '0; srt_ra = '0;
    ins_wd = {isp_q, val_q}; srt_wd = val_q;
    if (rv_q && rsp_ready_i) rv_d = 1'b0;
    case (state_q)
      stpf_pkg::S_IDLE: begin
        if (accept) begin
          val_d = value_i; pos_d = position_i;
          dat_d = '0; st_d = stpf_pkg::StOk;
          i_d = '0; w_d = '0; k_d = '0; found_d = 1'b0;
          isp_d = (value_i == 32'sd2) || (value_i == 32'sd3);
          div_d = 32'd2; rem_d = '0; dvd_d = value_i; dstep_d = '0;
          case (req_type_i)
            stpf_pkg::ReqInsert: begin
              if (cnt_q >= NW'(CAPACITY)) st_d = stpf_pkg::StFull;
              i_d = cnt_q;
            end
            stpf_pkg::ReqAsc: begin
              if (NW'(position_i) < cnt_q) srt_ra = AW'(position_i);
              else st_d = stpf_pkg::StRange;
            end
            stpf_pkg::ReqCross: begin
              if (NW'(position_i) < cnt_q)
                srt_ra = position_i[0] ? AW'(cross_idx) : AW'(position_i >> 1);
              else st_d = stpf_pkg::StRange;
            end
            stpf_pkg::ReqPrime: st_d = stpf_pkg::StRange;
            default: ;
          endcase
        end
      end
      stpf_pkg::S_PRIME: begin
        if (dstep_q != 6'd32) begin
          if (rem_sh >= {1'b0, div_q}) rem_d = 32'(rem_sh - {1'b0, div_q});
          else rem_d = rem_sh[31:0];
          dvd_d = dvd_q << 1;
          dstep_d = dstep_q + 6'd1;
        end else if (rem_q == 32'd0) begin
          isp_d = 1'b0;
        end else if (dsq > 64'(val_q)) begin
          isp_d = 1'b1;
        end else begin
          div_d = div_q + 32'd1; rem_d = '0; dvd_d = val_q; dstep_d = '0;
        end
      end
      stpf_pkg::S_INS_RD: begin
        if (i_q == '0) begin
          srt_we = 1'b1; srt_wa = '0;
          ins_we = 1'b1; ins_wa = AW'(cnt_q);
          cnt_d = cnt_q + NW'(1);
          if (isp_q) pcnt_d = pcnt_q + NW'(1);
        end else begin
          srt_ra = AW'(i_q - NW'(1));
        end
      end
      stpf_pkg::S_INS_CMP: begin
        srt_we = 1'b1; srt_wa = AW'(i_q);
        if (srt_rd_q > val_q) begin
          srt_wd = srt_rd_q;
          i_d = i_q - NW'(1);
        end else begin
          ins_we = 1'b1; ins_wa = AW'(cnt_q);
          cnt_d = cnt_q + NW'(1);
          if (isp_q) pcnt_d = pcnt_q + NW'(1);
        end
      end
      stpf_pkg::S_REM_SCAN: begin
        // read at i; handle entry i-1, whose read was issued in the previous cycle
        ins_ra = AW'(i_q);
        if (i_q != '0) begin
          if (rem_hit) found_d = 1'b1;
          else begin
            ins_we = 1'b1; ins_wa = AW'(w_q); ins_wd = ins_rd_q;
            w_d = w_q + NW'(1);
            if (ins_flg) k_d = k_q + NW'(1);
          end
        end
        if (i_q == cnt_q) begin
          if (found_d) begin
            st_d = stpf_pkg::StOk; i_d = '0;
            pcnt_d = k_d; k_d = w_d; w_d = '0;
          end else st_d = stpf_pkg::StNotFound;
        end else i_d = i_q + NW'(1);
      end
      stpf_pkg::S_REM_SORT: begin
        srt_ra = AW'(i_q);
        if (i_q != '0 && srt_rd_q != val_q) begin
          srt_we = 1'b1; srt_wa = AW'(w_q); srt_wd = srt_rd_q;
          w_d = w_q + NW'(1);
        end
        if (i_q == cnt_q) cnt_d = k_q;
        else i_d = i_q + NW'(1);
      end
      stpf_pkg::S_RD_WAIT: dat_d = srt_rd_q;
      stpf_pkg::S_PR_SCAN: begin
        ins_ra = AW'(i_q);
        if (i_q != '0 && ins_flg) begin
          if (k_q == NW'(pos_q)) begin
            dat_d = ins_val; st_d = stpf_pkg::StOk;
          end else k_d = k_q + NW'(1);
        end
        i_d = i_q + NW'(1);
      end
      stpf_pkg::S_OUT: rv_d = 1'b1;
      default: ;
    endcase
  end

  assign rsp_valid_o   = rv_q;
  assign data_o        = dat_q;
  assign status_o      = st_q;
  assign entry_count_o = stpf_pkg::CntW'(cnt_q);
  assign prime_count_o = stpf_pkg::CntW'(pcnt_q);

  `ASSERT_IMPL(a_cnt_cap, clk_i, rst_ni, 1'b1, cnt_q <= NW'(CAPACITY))
  `ASSERT_IMPL(a_pcnt_le, clk_i, rst_ni, state_q == stpf_pkg::S_IDLE, pcnt_q <= cnt_q)
  `ASSERT_NEXT(a_out_valid, clk_i, rst_ni, state_q == stpf_pkg::S_OUT, rsp_valid_o)
  `ASSERT_IMPL(a_busy_norsp, clk_i, rst_ni, state_q != stpf_pkg::S_IDLE, !rv_q)

endmodule

FILE: tb/sv/testbench.sv
// Self-checking bench for sorted_table_with_prime_filter: a queue-fed driver,
// a monitor and a table predictor that tracks the block's stores.
// Depends on stpf_pkg and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Cap = stpf_pkg::CapacityDef;
  localparam logic [stpf_pkg::ReqW-1:0] ReqRsvdLo = 3'd5;  // codes 5..7 leave the table unchanged

  typedef struct packed {
    logic [stpf_pkg::ReqW-1:0] kind;
    logic signed [31:0] value;
    logic [stpf_pkg::PosW-1:0] pos;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [stpf_pkg::StatW-1:0] status;
    logic [stpf_pkg::CntW-1:0] entries;
    logic [stpf_pkg::CntW-1:0] primes;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  logic [stpf_pkg::ReqW-1:0] req_type_i = '0;
  logic signed [31:0] value_i = '0;
  logic [stpf_pkg::PosW-1:0] position_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  logic signed [31:0] data_o;
  logic [stpf_pkg::StatW-1:0] status_o;
  logic [stpf_pkg::CntW-1:0] entry_count_o;
  logic [stpf_pkg::CntW-1:0] prime_count_o;

  sorted_table_with_prime_filter uut (.*);

  always #2 clk_i = ~clk_i;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int unsigned accepted = 0;
  int unsigned errors = 0;
  int unsigned send_idle = 34;
  int unsigned recv_idle = 62;
  int unsigned hold_left = 0;
  bit hold_done = 0;

  // shadow table
  logic signed [31:0] tbl_ins[Cap];
  bit tbl_prime[Cap];
  logic signed [31:0] tbl_sorted[Cap];
  int unsigned tbl_cnt = 0;
  int unsigned tbl_pcnt = 0;

  function automatic bit is_prime(logic signed [31:0] v);
    longint n, d;
    n = v;
    if (n <= 1) return 0;
    for (d = 2; d * d <= n; d++)
      if (n % d == 0) return 0;
    return 1;
  endfunction

  function automatic rsp_t table_apply(req_t r);
    rsp_t o;
    int unsigned slot, w, ws, pc, k;
    bit found;
    o.data = '0;
    o.status = stpf_pkg::StOk;
    case (r.kind)
      stpf_pkg::ReqInsert: begin
        if (tbl_cnt >= Cap) begin
          o.status = stpf_pkg::StFull;
        end else begin
          tbl_ins[tbl_cnt] = r.value;
          tbl_prime[tbl_cnt] = is_prime(r.value);
          slot = tbl_cnt;
          while (slot > 0 && tbl_sorted[slot-1] > r.value) begin
            tbl_sorted[slot] = tbl_sorted[slot-1];
            slot--;
          end
          tbl_sorted[slot] = r.value;
          if (tbl_prime[tbl_cnt]) tbl_pcnt++;
          tbl_cnt++;
        end
      end
      stpf_pkg::ReqRemove: begin
        found = 0;
        w = 0;
        pc = 0;
        for (int unsigned i = 0; i < tbl_cnt; i++) begin
          if (tbl_ins[i] == r.value) begin
            found = 1;
          end else begin
            tbl_ins[w] = tbl_ins[i];
            tbl_prime[w] = tbl_prime[i];
            if (tbl_prime[w]) pc++;
            w++;
          end
        end
        if (!found) begin
          o.status = stpf_pkg::StNotFound;
        end else begin
          ws = 0;
          for (int unsigned i = 0; i < tbl_cnt; i++)
            if (tbl_sorted[i] != r.value) begin
              tbl_sorted[ws] = tbl_sorted[i];
              ws++;
            end
          tbl_cnt = w;
          tbl_pcnt = pc;
        end
      end
      stpf_pkg::ReqAsc: begin
        if (r.pos < tbl_cnt) o.data = tbl_sorted[r.pos];
        else o.status = stpf_pkg::StRange;
      end
      stpf_pkg::ReqCross: begin
        if (r.pos >= tbl_cnt) o.status = stpf_pkg::StRange;
        else if (!r.pos[0]) o.data = tbl_sorted[r.pos >> 1];
        else o.data = tbl_sorted[tbl_cnt - 1 - (r.pos >> 1)];
      end
      stpf_pkg::ReqPrime: begin
        o.status = stpf_pkg::StRange;
        k = 0;
        for (int unsigned i = 0; i < tbl_cnt; i++)
          if (tbl_prime[i]) begin
            if (k == r.pos) begin
              o.data = tbl_ins[i];
              o.status = stpf_pkg::StOk;
              break;
            end
            k++;
          end
      end
      default: ;
    endcase
    o.entries = tbl_cnt[stpf_pkg::CntW-1:0];
    o.primes = tbl_pcnt[stpf_pkg::CntW-1:0];
    return o;
  endfunction

  // driver: predicts at acceptance, then offers the next pending request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
    end else begin
      if (req_valid_i && req_ready_o) begin
        expected_rsps.insert(expected_rsps.size(),
                             table_apply('{req_type_i, value_i, position_i}));
        accepted++;
      end
      if (!req_valid_i || req_ready_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          req_t r;
          r = pending_reqs.pop_front();
          req_type_i <= r.kind;
          value_i <= r.value;
          position_i <= r.pos;
          req_valid_i <= 1'b1;
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and response backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
    end else begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response data=%0d status=%0d", data_o, status_o);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (data_o !== e.data) begin
            $error("data: expected %0d, got %0d", e.data, data_o);
            errors++;
          end
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o);
            errors++;
          end
          if (entry_count_o !== e.entries) begin
            $error("entry_count: expected %0d, got %0d", e.entries, entry_count_o);
            errors++;
          end
          if (prime_count_o !== e.primes) begin
            $error("prime_count: expected %0d, got %0d", e.primes, prime_count_o);
            errors++;
          end
        end
      end
      if (!hold_done && accepted >= 300) begin
        hold_done = 1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready_i <= 1'b0;
      end else begin
        rsp_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic void queue_req(logic [stpf_pkg::ReqW-1:0] kind,
                                    logic signed [31:0] v,
                                    logic [stpf_pkg::PosW-1:0] p);
    req_t r;
    r.kind = kind;
    r.value = v;
    r.pos = p;
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // values kept small or fast to test: large odd primes would make the serial
  // trial division try every divisor up to their square root
  function automatic logic signed [31:0] rand_value();
    int unsigned sel;
    logic signed [31:0] v;
    sel = $urandom_range(99);
    if (sel < 80) begin
      v = $urandom_range(300);
    end else if (sel < 90) begin
      v = -$signed({1'b0, 31'($urandom)});
    end else begin
      v = $urandom;
      v[0] = 1'b0;
      v[31] = 1'b0;
    end
    return v;
  endfunction

  initial begin
    int unsigned insert_w;
    int unsigned sel;
    queue_req(stpf_pkg::ReqAsc, 0, 0);
    queue_req(stpf_pkg::ReqPrime, 0, 0);
    queue_req(stpf_pkg::ReqRemove, 5, 0);
    queue_req(stpf_pkg::ReqInsert, 32'sh8000_0000, 0);
    queue_req(stpf_pkg::ReqInsert, 32'sh7fff_fffe, 0);
    queue_req(stpf_pkg::ReqInsert, 0, 0);
    queue_req(stpf_pkg::ReqInsert, 1, 0);
    queue_req(stpf_pkg::ReqInsert, 2, 0);
    queue_req(stpf_pkg::ReqInsert, 3, 0);
    queue_req(stpf_pkg::ReqInsert, 4, 0);
    queue_req(stpf_pkg::ReqInsert, 97, 0);
    queue_req(stpf_pkg::ReqInsert, -5, 0);
    queue_req(stpf_pkg::ReqInsert, 97, 0);
    queue_req(stpf_pkg::ReqAsc, 32'hffff_ffff, 0);
    queue_req(stpf_pkg::ReqAsc, 0, 63);
    queue_req(stpf_pkg::ReqCross, 0, 0);
    queue_req(stpf_pkg::ReqCross, 0, 1);
    queue_req(stpf_pkg::ReqCross, 0, 2);
    queue_req(stpf_pkg::ReqCross, 0, 63);
    queue_req(stpf_pkg::ReqPrime, 0, 1);
    queue_req(stpf_pkg::ReqPrime, 0, 63);
    queue_req(stpf_pkg::ReqRemove, 97, 0);
    queue_req(stpf_pkg::ReqRemove, 32'sh7fff_ffff, 0);
    queue_req(stpf_pkg::ReqPrime, 0, 1);
    queue_req(ReqRsvdLo, $urandom, 6'($urandom));
    queue_req(ReqRsvdLo + 3'd2, 0, 0);
    // random part in runs that lean toward filling or draining the table
    insert_w = 70;
    for (int i = 0; i < 1700; i++) begin
      if (i % 120 == 0) insert_w = ($urandom_range(1) != 0) ? 75 : 25;
      sel = $urandom_range(99);
      if (sel < insert_w / 2 + 10) begin
        queue_req(stpf_pkg::ReqInsert, rand_value(), 6'($urandom));
      end else if (sel < 55) begin
        queue_req(stpf_pkg::ReqRemove,
          ($urandom_range(9) == 0) ? rand_value() : $urandom_range(300),
          6'($urandom));
      end else if (sel < 97) begin
        queue_req(stpf_pkg::ReqAsc + 3'($urandom_range(2)), $urandom,
                  6'($urandom));
      end else begin
        queue_req(ReqRsvdLo + 3'($urandom_range(2)), $urandom, 6'($urandom));
      end
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (accepted >= 600);
    send_idle = 62;
    recv_idle = 34;
    wait (accepted >= 1200);
    send_idle = 0;
    recv_idle = 0;
    wait (pending_reqs.size() == 0 && !req_valid_i && expected_rsps.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
